// ----- rtl/rdwi_pkg.sv -----
// Shared types and field widths for the reversible deque with index.
package rdwi_pkg;

    localparam int ACTION_W = 4;
    localparam int INDEX_W  = 10;
    localparam int VALUE_W  = 64;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 11;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH_LEFT  = 4'd0,
        ACT_PUSH_RIGHT = 4'd1,
        ACT_POP_LEFT   = 4'd2,
        ACT_POP_RIGHT  = 4'd3,
        ACT_PEEK_LEFT  = 4'd4,
        ACT_PEEK_RIGHT = 4'd5,
        ACT_GET        = 4'd6,
        ACT_SET        = 4'd7,
        ACT_REVERSE    = 4'd8,
        ACT_CLEAR      = 4'd9
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_RANGE = 2'd2,
        STAT_FULL  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_EXEC,
        FSM_RESP
    } fsm_state_t;

endpackage

// ----- rtl/rdwi_ram.sv -----
// Single-port value store with registered read data.
module rdwi_ram #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10,
    parameter int DATA_W = 64
) (
    input  logic              aclk,
    input  logic              en,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  logic [DATA_W-1:0] wdata,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/reversible_deque_with_index_unit.sv -----
// Top level of the reversible deque: control, pointers and result register.
//
// Bounded double-ended queue of signed 64-bit values in a ring buffer of DEPTH entries.
// Each transaction carries one action and returns one result with the status, the value
// read by a peek or get (zero otherwise) and the element count after the action. The
// result is loaded through two states after acceptance: the EXEC state accesses the
// single-port value store, and the RESP state captures the registered read data once
// the output is free. The block takes no new item until the result of the last one
// is loaded. The next item is accepted while a finished result still waits on the
// output.
// Clear only resets the pointer, count and orientation; it takes no sweep of the store.
module reversible_deque_with_index_unit #(
    parameter int DEPTH = 1024
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [rdwi_pkg::ACTION_W-1:0]        s_action,
    input  logic [rdwi_pkg::INDEX_W-1:0]         s_index,
    input  logic signed [rdwi_pkg::VALUE_W-1:0]  s_write_value,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [rdwi_pkg::STATUS_W-1:0]        m_status,
    output logic signed [rdwi_pkg::VALUE_W-1:0]  m_read_value,
    output logic [rdwi_pkg::COUNT_W-1:0]         m_element_count
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > rdwi_pkg::INDEX_W) ? CW : rdwi_pkg::INDEX_W;
    localparam int OW = (CW > rdwi_pkg::COUNT_W) ? CW : rdwi_pkg::COUNT_W;
    localparam logic [PW:0]   DEPTH_S   = (PW + 1)'(DEPTH);
    localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_C   = CW'(DEPTH);

    rdwi_pkg::fsm_state_t state_reg, state_next;

    rdwi_pkg::action_t              act_reg;
    logic [rdwi_pkg::INDEX_W-1:0]   idx_reg;
    logic [rdwi_pkg::VALUE_W-1:0]   wv_reg;

    logic [PW-1:0] front_reg, front_next;
    logic [CW-1:0] count_reg, count_next;
    logic          rev_reg, rev_next;

    rdwi_pkg::status_t resp_status_reg, resp_status_next;
    logic              resp_rd_reg, resp_rd_next;

    logic                                m_valid_reg;
    rdwi_pkg::status_t                   m_status_reg;
    logic [rdwi_pkg::VALUE_W-1:0]        m_value_reg;
    logic [rdwi_pkg::COUNT_W-1:0]        m_count_reg;

    logic                         mem_en, mem_we;
    logic [PW-1:0]                mem_addr;
    logic [rdwi_pkg::VALUE_W-1:0] mem_rdata;

    logic          s_fire, load_out;
    logic          is_left, front_side, is_full, is_empty, in_range;
    logic [XW-1:0] idx_x, count_x;
    logic [CW-1:0] idx_c, pos_c;
    logic [PW:0]   sum;
    logic [PW-1:0] slot, push_front_addr;
    logic [OW-1:0] count_wide;

    assign s_ready  = (state_reg == rdwi_pkg::FSM_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign load_out = (state_reg == rdwi_pkg::FSM_RESP) && (!m_valid_reg || m_ready);

    assign is_left = (act_reg == rdwi_pkg::ACT_PUSH_LEFT) ||
                     (act_reg == rdwi_pkg::ACT_POP_LEFT)  ||
                     (act_reg == rdwi_pkg::ACT_PEEK_LEFT);
    assign front_side = is_left != rev_reg;
    assign is_full    = (count_reg == DEPTH_C);
    assign is_empty   = (count_reg == '0);

    assign idx_x    = XW'(idx_reg);
    assign count_x  = XW'(count_reg);
    assign in_range = idx_x < count_x;
    assign idx_c    = idx_x[CW-1:0];

    // Physical position relative to the front pointer that the action touches.
    always_comb begin
        pos_c = '0;
        case (act_reg) inside
            rdwi_pkg::ACT_PUSH_LEFT, rdwi_pkg::ACT_PUSH_RIGHT: pos_c = count_reg;
            rdwi_pkg::ACT_POP_LEFT, rdwi_pkg::ACT_POP_RIGHT:   pos_c = CW'(1);
            rdwi_pkg::ACT_PEEK_LEFT, rdwi_pkg::ACT_PEEK_RIGHT:
                pos_c = front_side ? '0 : (count_reg - CW'(1));
            rdwi_pkg::ACT_GET, rdwi_pkg::ACT_SET:
                pos_c = rev_reg ? (count_reg - CW'(1) - idx_c) : idx_c;
            default: pos_c = '0;
        endcase
    end

    // Ring wrap: both operands are below DEPTH, so one subtract suffices.
    assign sum  = {1'b0, front_reg} + {1'b0, pos_c[PW-1:0]};
    assign slot = (sum >= DEPTH_S) ? PW'(sum - DEPTH_S) : sum[PW-1:0];
    assign push_front_addr = (front_reg == '0) ? LAST_SLOT : (front_reg - PW'(1));

    always_comb begin
        state_next       = state_reg;
        front_next       = front_reg;
        count_next       = count_reg;
        rev_next         = rev_reg;
        resp_status_next = rdwi_pkg::STAT_OK;
        resp_rd_next     = 1'b0;
        mem_en           = 1'b0;
        mem_we           = 1'b0;
        mem_addr         = slot;
        unique case (state_reg)
            rdwi_pkg::FSM_IDLE: begin
                if (s_fire) begin
                    state_next = rdwi_pkg::FSM_EXEC;
                end
            end
            rdwi_pkg::FSM_EXEC: begin
                state_next = rdwi_pkg::FSM_RESP;
                case (act_reg) inside
                    rdwi_pkg::ACT_PUSH_LEFT, rdwi_pkg::ACT_PUSH_RIGHT: begin
                        if (is_full) begin
                            resp_status_next = rdwi_pkg::STAT_FULL;
                        end else begin
                            mem_en     = 1'b1;
                            mem_we     = 1'b1;
                            count_next = count_reg + CW'(1);
                            if (front_side) begin
                                mem_addr   = push_front_addr;
                                front_next = push_front_addr;
                            end
                        end
                    end
                    rdwi_pkg::ACT_POP_LEFT, rdwi_pkg::ACT_POP_RIGHT: begin
                        if (is_empty) begin
                            resp_status_next = rdwi_pkg::STAT_EMPTY;
                        end else begin
                            count_next = count_reg - CW'(1);
                            if (front_side) begin
                                front_next = slot;
                            end
                        end
                    end
                    rdwi_pkg::ACT_PEEK_LEFT, rdwi_pkg::ACT_PEEK_RIGHT: begin
                        if (is_empty) begin
                            resp_status_next = rdwi_pkg::STAT_EMPTY;
                        end else begin
                            mem_en       = 1'b1;
                            resp_rd_next = 1'b1;
                        end
                    end
                    rdwi_pkg::ACT_GET, rdwi_pkg::ACT_SET: begin
                        if (!in_range) begin
                            resp_status_next = rdwi_pkg::STAT_RANGE;
                        end else begin
                            mem_en = 1'b1;
                            if (act_reg == rdwi_pkg::ACT_SET) begin
                                mem_we = 1'b1;
                            end else begin
                                resp_rd_next = 1'b1;
                            end
                        end
                    end
                    rdwi_pkg::ACT_REVERSE: rev_next = !rev_reg;
                    rdwi_pkg::ACT_CLEAR: begin
                        front_next = '0;
                        count_next = '0;
                        rev_next   = 1'b0;
                    end
                    default: ;
                endcase
            end
            rdwi_pkg::FSM_RESP: begin
                if (load_out) begin
                    state_next = rdwi_pkg::FSM_IDLE;
                end
            end
            default: state_next = rdwi_pkg::FSM_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rdwi_pkg::FSM_IDLE;
            front_reg <= '0;
            count_reg <= '0;
            rev_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            front_reg <= front_next;
            count_reg <= count_next;
            rev_reg   <= rev_next;
        end
    end

    // Latch the accepted transaction and the outcome of the store access.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            act_reg <= rdwi_pkg::action_t'(s_action);
            idx_reg <= s_index;
            wv_reg  <= s_write_value;
        end
        if (state_reg == rdwi_pkg::FSM_EXEC) begin
            resp_status_reg <= resp_status_next;
            resp_rd_reg     <= resp_rd_next;
        end
    end

    assign count_wide = OW'(count_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_status_reg <= resp_status_reg;
            m_value_reg  <= resp_rd_reg ? mem_rdata : '0;
            m_count_reg  <= count_wide[rdwi_pkg::COUNT_W-1:0];
        end
    end

    rdwi_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (PW),
        .DATA_W (rdwi_pkg::VALUE_W)
    ) u_store (
        .aclk  (aclk),
        .en    (mem_en),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (wv_reg),
        .rdata (mem_rdata)
    );

    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_read_value    = m_value_reg;
    assign m_element_count = m_count_reg;

endmodule

// ----- sim/reversible_deque_with_index_unit_test.sv -----
// Self-checking testbench for the reversible deque with index: shadow deque, random traffic.
module reversible_deque_with_index_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH      = 1024;
    localparam int IDLE_LIMIT = 3000;
    localparam int LONG_HOLD  = 300;

    localparam logic [rdwi_pkg::VALUE_W-1:0] VAL_MIN  = 64'h8000_0000_0000_0000;
    localparam logic [rdwi_pkg::VALUE_W-1:0] VAL_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [rdwi_pkg::VALUE_W-1:0] VAL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        rdwi_pkg::status_t                   status;
        logic signed [rdwi_pkg::VALUE_W-1:0] value;
        logic [rdwi_pkg::COUNT_W-1:0]        count;
    } deque_result_t;

    // Shadow deque: mirrors the ring buffer and queues the result each transaction causes.
    class deque_shadow;
        logic signed [rdwi_pkg::VALUE_W-1:0] slots [DEPTH];
        logic [rdwi_pkg::INDEX_W-1:0]        head    = '0;
        logic [rdwi_pkg::COUNT_W-1:0]        fill    = '0;
        bit                                  flipped = 1'b0;
        deque_result_t                       pending_results [$];
        int                                  errors  = 0;

        function void record_action(logic [rdwi_pkg::ACTION_W-1:0] act,
                                    logic [rdwi_pkg::INDEX_W-1:0] idx,
                                    logic signed [rdwi_pkg::VALUE_W-1:0] wv);
            deque_result_t                res;
            logic [rdwi_pkg::INDEX_W-1:0] pos;
            logic [rdwi_pkg::INDEX_W-1:0] slot;
            res.status = rdwi_pkg::STAT_OK;
            res.value  = '0;
            case (act)
                rdwi_pkg::ACT_PUSH_LEFT, rdwi_pkg::ACT_PUSH_RIGHT: begin
                    if (fill == DEPTH) begin
                        res.status = rdwi_pkg::STAT_FULL;
                    end else if ((act == rdwi_pkg::ACT_PUSH_LEFT) != flipped) begin
                        head = head - 10'd1;
                        slots[head] = wv;
                        fill = fill + 11'd1;
                    end else begin
                        slot = 10'(head + fill);
                        slots[slot] = wv;
                        fill = fill + 11'd1;
                    end
                end
                rdwi_pkg::ACT_POP_LEFT, rdwi_pkg::ACT_POP_RIGHT: begin
                    if (fill == 0) begin
                        res.status = rdwi_pkg::STAT_EMPTY;
                    end else if ((act == rdwi_pkg::ACT_POP_LEFT) != flipped) begin
                        head = head + 10'd1;
                        fill = fill - 11'd1;
                    end else begin
                        fill = fill - 11'd1;
                    end
                end
                rdwi_pkg::ACT_PEEK_LEFT, rdwi_pkg::ACT_PEEK_RIGHT: begin
                    if (fill == 0) begin
                        res.status = rdwi_pkg::STAT_EMPTY;
                    end else if ((act == rdwi_pkg::ACT_PEEK_LEFT) != flipped) begin
                        res.value = slots[head];
                    end else begin
                        slot = 10'(head + fill - 11'd1);
                        res.value = slots[slot];
                    end
                end
                rdwi_pkg::ACT_GET, rdwi_pkg::ACT_SET: begin
                    if ({1'b0, idx} >= fill) begin
                        res.status = rdwi_pkg::STAT_RANGE;
                    end else begin
                        // logical index counts from the far end when the view is flipped
                        pos  = 10'(flipped ? fill - 11'd1 - {1'b0, idx} : {1'b0, idx});
                        slot = 10'(head + pos);
                        if (act == rdwi_pkg::ACT_GET) begin
                            res.value = slots[slot];
                        end else begin
                            slots[slot] = wv;
                        end
                    end
                end
                rdwi_pkg::ACT_REVERSE: begin
                    flipped = !flipped;
                end
                rdwi_pkg::ACT_CLEAR: begin
                    head    = '0;
                    fill    = '0;
                    flipped = 1'b0;
                end
                default: begin
                end
            endcase
            res.count = fill;
            pending_results.push_back(res);
        endfunction

        function void check_result(logic [rdwi_pkg::STATUS_W-1:0] st,
                                   logic signed [rdwi_pkg::VALUE_W-1:0] rv,
                                   logic [rdwi_pkg::COUNT_W-1:0] cnt);
            deque_result_t want;
            if (pending_results.size() == 0) begin
                $error("result transaction with none outstanding");
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (st !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, st);
                errors++;
            end
            if (rv !== want.value) begin
                $error("read_value: expected %0d, actual %0d", want.value, rv);
                errors++;
            end
            if (cnt !== want.count) begin
                $error("element_count: expected %0d, actual %0d", want.count, cnt);
                errors++;
            end
        endfunction

        function int outstanding();
            return pending_results.size();
        endfunction
    endclass

    logic                                  aclk = 1'b0;
    logic                                  aresetn = 1'b0;
    logic                                  s_valid;
    logic                                  s_ready;
    logic [rdwi_pkg::ACTION_W-1:0]         s_action;
    logic [rdwi_pkg::INDEX_W-1:0]          s_index;
    logic signed [rdwi_pkg::VALUE_W-1:0]   s_write_value;
    logic                                  m_valid;
    logic                                  m_ready;
    logic [rdwi_pkg::STATUS_W-1:0]         m_status;
    logic signed [rdwi_pkg::VALUE_W-1:0]   m_read_value;
    logic [rdwi_pkg::COUNT_W-1:0]          m_element_count;

    deque_shadow shadow = new();
    int          gen_count = 0;
    bit          no_idle   = 1'b0;
    bit          hold_long = 1'b0;

    reversible_deque_with_index_unit #(.DEPTH(DEPTH)) dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_action        (s_action),
        .s_index         (s_index),
        .s_write_value   (s_write_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_read_value    (m_read_value),
        .m_element_count (m_element_count)
    );

    always #2 aclk = ~aclk;

    // Present one transaction after a random gap (none when no_idle is set) and hold it until accepted.
    task automatic drive_item(input logic [rdwi_pkg::ACTION_W-1:0] act,
                              input logic [rdwi_pkg::INDEX_W-1:0] idx,
                              input logic [rdwi_pkg::VALUE_W-1:0] wv);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_action      <= act;
        s_index       <= idx;
        s_write_value <= wv;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        shadow.record_action(act, idx, wv);
        case (act)
            rdwi_pkg::ACT_PUSH_LEFT, rdwi_pkg::ACT_PUSH_RIGHT:
                if (gen_count < DEPTH) gen_count++;
            rdwi_pkg::ACT_POP_LEFT, rdwi_pkg::ACT_POP_RIGHT:
                if (gen_count > 0) gen_count--;
            rdwi_pkg::ACT_CLEAR: gen_count = 0;
            default: begin
            end
        endcase
    endtask

    task automatic random_item(input int push_pct, input int pop_pct, input bit allow_clear);
        int                            r;
        logic [rdwi_pkg::ACTION_W-1:0] act;
        logic [rdwi_pkg::INDEX_W-1:0]  idx;
        logic [rdwi_pkg::VALUE_W-1:0]  wv;
        r = $urandom_range(0, 99);
        if (r < push_pct) begin
            act = $urandom_range(0, 1) ? rdwi_pkg::ACT_PUSH_RIGHT : rdwi_pkg::ACT_PUSH_LEFT;
        end else if (r < push_pct + pop_pct) begin
            act = $urandom_range(0, 1) ? rdwi_pkg::ACT_POP_RIGHT : rdwi_pkg::ACT_POP_LEFT;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 20) begin
                act = $urandom_range(0, 1) ? rdwi_pkg::ACT_PEEK_RIGHT : rdwi_pkg::ACT_PEEK_LEFT;
            end else if (r < 70) begin
                act = $urandom_range(0, 1) ? rdwi_pkg::ACT_SET : rdwi_pkg::ACT_GET;
            end else if (r < 84 || (r < 88 && !allow_clear)) begin
                act = rdwi_pkg::ACT_REVERSE;
            end else if (r < 88) begin
                act = rdwi_pkg::ACT_CLEAR;
            end else begin
                act = 4'($urandom_range(10, 15));
            end
        end
        // mostly live positions, now and then any index
        if (gen_count > 0 && $urandom_range(0, 4) != 0) begin
            idx = 10'($urandom_range(0, gen_count - 1));
        end else begin
            idx = 10'($urandom);
        end
        case ($urandom_range(0, 19))
            0:       wv = VAL_MIN;
            1:       wv = VAL_MAX;
            2:       wv = VAL_ONES;
            3:       wv = '0;
            default: wv = {$urandom, $urandom};
        endcase
        drive_item(act, idx, wv);
    endtask

    // Drop valid and hold off until every expected result has come back.
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (shadow.outstanding() != 0) @(posedge aclk);
    endtask

    initial begin : result_sink
        int gap;
        m_ready <= 1'b0;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_long) begin
                hold_long = 1'b0;
                gap = LONG_HOLD;
            end else begin
                gap = no_idle ? 0 : $urandom_range(0, 9);
            end
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            shadow.check_result(m_status, m_read_value, m_element_count);
        end
    end

    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
                idle = 0;
            end else begin
                idle++;
            end
        end
        $display("*** FAILED ***");
        $finish;
    end

    initial begin : stimulus
        s_valid       <= 1'b0;
        s_action      <= '0;
        s_index       <= '0;
        s_write_value <= '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty deque: every access is refused
        drive_item(rdwi_pkg::ACT_POP_LEFT,   10'd0,    '0);
        drive_item(rdwi_pkg::ACT_POP_RIGHT,  10'd0,    '0);
        drive_item(rdwi_pkg::ACT_PEEK_LEFT,  10'd0,    '0);
        drive_item(rdwi_pkg::ACT_PEEK_RIGHT, 10'd0,    '0);
        drive_item(rdwi_pkg::ACT_GET,        10'd0,    '0);
        drive_item(rdwi_pkg::ACT_SET,        10'd1023, VAL_ONES);
        // extreme values at both ends
        drive_item(rdwi_pkg::ACT_PUSH_LEFT,  10'd0,    VAL_MIN);
        drive_item(rdwi_pkg::ACT_PUSH_RIGHT, 10'd1023, VAL_MAX);
        drive_item(rdwi_pkg::ACT_PUSH_RIGHT, 10'd0,    VAL_ONES);
        drive_item(rdwi_pkg::ACT_PUSH_LEFT,  10'd0,    '0);
        drive_item(rdwi_pkg::ACT_PEEK_LEFT,  10'd0,    '0);
        drive_item(rdwi_pkg::ACT_PEEK_RIGHT, 10'd0,    '0);
        drive_item(rdwi_pkg::ACT_GET,        10'd3,    '0);
        drive_item(rdwi_pkg::ACT_GET,        10'd4,    '0);
        drive_item(rdwi_pkg::ACT_SET,        10'd1,    64'h5555_5555_5555_5555);
        drive_item(rdwi_pkg::ACT_GET,        10'd1,    '0);
        // flipped view swaps ends and index order
        drive_item(rdwi_pkg::ACT_REVERSE,    10'd0,    '0);
        drive_item(rdwi_pkg::ACT_PEEK_LEFT,  10'd0,    '0);
        drive_item(rdwi_pkg::ACT_GET,        10'd0,    '0);
        drive_item(rdwi_pkg::ACT_PUSH_LEFT,  10'd0,    64'h0123_4567_89AB_CDEF);
        drive_item(rdwi_pkg::ACT_POP_RIGHT,  10'd0,    '0);
        drive_item(rdwi_pkg::ACT_PEEK_RIGHT, 10'd0,    '0);
        drive_item(4'd10,                    10'd0,    '0);
        drive_item(4'd15,                    10'd1023, VAL_ONES);
        drive_item(rdwi_pkg::ACT_CLEAR,      10'd0,    '0);
        drive_item(rdwi_pkg::ACT_PEEK_LEFT,  10'd0,    '0);

        repeat (350) random_item(35, 20, 1'b1);
        wait_drained();

        // fill to capacity while the sink holds off once for a long stretch
        drive_item(rdwi_pkg::ACT_CLEAR, 10'd0, '0);
        hold_long = 1'b1;
        while (gen_count < DEPTH) random_item(85, 3, 1'b0);
        repeat (30) random_item(50, 0, 1'b0);
        drive_item(rdwi_pkg::ACT_GET, 10'd1023, '0);
        drive_item(rdwi_pkg::ACT_SET, 10'd1023, VAL_MIN);
        drive_item(rdwi_pkg::ACT_GET, 10'd1023, '0);
        drive_item(rdwi_pkg::ACT_PUSH_LEFT, 10'd0, VAL_MAX);
        drive_item(rdwi_pkg::ACT_REVERSE, 10'd0, '0);
        drive_item(rdwi_pkg::ACT_GET, 10'd1023, '0);
        drive_item(rdwi_pkg::ACT_PUSH_RIGHT, 10'd0, VAL_MAX);
        wait_drained();

        // back-to-back transactions on both sides, then drain with random gaps
        no_idle = 1'b1;
        repeat (100) random_item(30, 40, 1'b0);
        no_idle = 1'b0;
        repeat (250) random_item(25, 40, 1'b1);

        wait_drained();
        repeat (10) @(posedge aclk);
        if (shadow.errors == 0 && shadow.outstanding() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ----- reversible_deque_with_index_unit.f -----
rtl/rdwi_pkg.sv
rtl/rdwi_ram.sv
rtl/reversible_deque_with_index_unit.sv
sim/reversible_deque_with_index_unit_test.sv
